### sv/dh_forward_kinematics_3joint_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the forward kinematics block
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DH_FORWARD_KINEMATICS_3JOINT_ASSERT_SVH
`define DH_FORWARD_KINEMATICS_3JOINT_ASSERT_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPLY(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### sv/dhfk_pkg.sv
// ----------------------------------------------------------------------------
// dhfk_pkg
// Shared constants, types and the arctangent table of the sine/cosine unit.
// ----------------------------------------------------------------------------
package dhfk_pkg;

	localparam int CORDIC_STEPS = 28;
	localparam int TRIG_W       = 32;
	localparam int CORDIC_W     = 34;
	localparam int CFG_IDX_W    = 4;
	localparam int CODE_W       = 6;

	localparam logic [31:0] GAIN_INV = 32'd652032874;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_YAW_LEN    = 4'd0,
		REG_PITCH_LEN  = 4'd1,
		REG_ROLL_LEN   = 4'd2,
		REG_YAW_OFS    = 4'd3,
		REG_PITCH_OFS  = 4'd4,
		REG_ROLL_OFS   = 4'd5,
		REG_TWIST      = 4'd6,
		REG_ANGLE_OFS  = 4'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		QT_0   = 2'd0,
		QT_90  = 2'd1,
		QT_180 = 2'd2,
		QT_270 = 2'd3
	} quarter_t;

	localparam logic [CODE_W-1:0] TWIST_RESET = 6'd17;
	localparam logic [CODE_W-1:0] AOFS_RESET  = 6'd17;

	typedef struct packed {
		logic valid;
		logic sat;
	} link_ctl_t;

	function automatic logic [31:0] atan_lut(input int unsigned i);
		logic [31:0] r;
		unique case (i)
			0:  r = 32'h20000000;
			1:  r = 32'h12E4051E;
			2:  r = 32'h09FB385B;
			3:  r = 32'h051111D4;
			4:  r = 32'h028B0D43;
			5:  r = 32'h0145D7E1;
			6:  r = 32'h00A2F61E;
			7:  r = 32'h00517C55;
			8:  r = 32'h0028BE53;
			9:  r = 32'h00145F2F;
			10: r = 32'h000A2F98;
			11: r = 32'h000517CC;
			12: r = 32'h00028BE6;
			13: r = 32'h000145F3;
			14: r = 32'h0000A2FA;
			15: r = 32'h0000517D;
			16: r = 32'h000028BE;
			17: r = 32'h0000145F;
			18: r = 32'h00000A30;
			19: r = 32'h00000518;
			20: r = 32'h0000028C;
			21: r = 32'h00000146;
			22: r = 32'h000000A3;
			23: r = 32'h00000051;
			24: r = 32'h00000029;
			25: r = 32'h00000014;
			26: r = 32'h0000000A;
			27: r = 32'h00000005;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

endpackage

### sv/dhfk_if.sv
// ----------------------------------------------------------------------------
// dhfk channel interfaces
// Pose input, result output and register write channels.
// ----------------------------------------------------------------------------
interface dhfk_pose_if #(
	parameter int CW = 24,
	parameter int AW = 16
);
	logic                 valid;
	logic                 ready;
	logic        [AW-1:0] yaw_angle;
	logic        [AW-1:0] pitch_angle;
	logic        [AW-1:0] roll_angle;
	logic signed [CW-1:0] point_x;
	logic signed [CW-1:0] point_y;
	logic signed [CW-1:0] point_z;

	modport source (output valid, yaw_angle, pitch_angle, roll_angle,
		point_x, point_y, point_z, input ready);
	modport sink (input valid, yaw_angle, pitch_angle, roll_angle,
		point_x, point_y, point_z, output ready);
endinterface

interface dhfk_result_if #(
	parameter int CW = 24
);
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] out_x;
	logic signed [CW-1:0] out_y;
	logic signed [CW-1:0] out_z;
	logic                 saturated;

	modport source (output valid, out_x, out_y, out_z, saturated, input ready);
	modport sink (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

interface dhfk_cfg_if import dhfk_pkg::*; #(
	parameter int CW = 24
);
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CW-1:0]        data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### sv/dhfk_cordic.sv
// ----------------------------------------------------------------------------
// dhfk_cordic
// Pipelined sine/cosine, one rotation step per stage, quadrant fold and an
// optional delay tail to line up with later links.
// ----------------------------------------------------------------------------
module dhfk_cordic import dhfk_pkg::*; #(
	parameter int TAIL = 0
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [31:0]              phase,
	output logic signed [TRIG_W-1:0] cos_o,
	output logic signed [TRIG_W-1:0] sin_o
);

	localparam logic signed [CORDIC_W-1:0] ONE  = CORDIC_W'(34'sd1 <<< 30);
	localparam logic signed [CORDIC_W-1:0] MONE = -ONE;

	logic signed [CORDIC_W-1:0] x_s [0:CORDIC_STEPS];
	logic signed [CORDIC_W-1:0] y_s [0:CORDIC_STEPS];
	logic signed [CORDIC_W-1:0] z_s [0:CORDIC_STEPS];
	logic [1:0]                 q_s [0:CORDIC_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= CORDIC_W'(GAIN_INV);
			y_s[0] <= '0;
			z_s[0] <= CORDIC_W'(phase[29:0]);
			q_s[0] <= phase[31:30];
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		localparam logic signed [CORDIC_W-1:0] ATN = CORDIC_W'(atan_lut(i));
		always_ff @(posedge clk) begin
			if (en) begin
				q_s[i+1] <= q_s[i];
				if (!z_s[i][CORDIC_W-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ATN;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ATN;
				end
			end
		end
	end

	logic signed [CORDIC_W-1:0] xc, yc;
	logic signed [TRIG_W-1:0]   cx, cy, c_fold, s_fold;

	always_comb begin
		xc = x_s[CORDIC_STEPS];
		yc = y_s[CORDIC_STEPS];
		if (xc > ONE) xc = ONE;
		else if (xc < MONE) xc = MONE;
		if (yc > ONE) yc = ONE;
		else if (yc < MONE) yc = MONE;
		cx = TRIG_W'(xc);
		cy = TRIG_W'(yc);
		unique case (quarter_t'(q_s[CORDIC_STEPS]))
			QT_0:   begin c_fold = cx;  s_fold = cy;  end
			QT_90:  begin c_fold = -cy; s_fold = cx;  end
			QT_180: begin c_fold = -cx; s_fold = -cy; end
			QT_270: begin c_fold = cy;  s_fold = -cx; end
			default: begin c_fold = cx; s_fold = cy; end
		endcase
	end

	if (TAIL == 0) begin : g_notail
		assign cos_o = c_fold;
		assign sin_o = s_fold;
	end else begin : g_tail
		logic signed [TRIG_W-1:0] c_t_q [0:TAIL-1];
		logic signed [TRIG_W-1:0] s_t_q [0:TAIL-1];
		always_ff @(posedge clk) begin
			if (en) begin
				c_t_q[0] <= c_fold;
				s_t_q[0] <= s_fold;
				for (int k = 1; k < TAIL; k++) begin
					c_t_q[k] <= c_t_q[k-1];
					s_t_q[k] <= s_t_q[k-1];
				end
			end
		end
		assign cos_o = c_t_q[TAIL-1];
		assign sin_o = s_t_q[TAIL-1];
	end

endmodule

### sv/dhfk_link.sv
// ----------------------------------------------------------------------------
// dhfk_link
// One link transform in three stages: twist and add, multiply, round and
// saturate.
// ----------------------------------------------------------------------------
module dhfk_link import dhfk_pkg::*; #(
	parameter int CW = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  link_ctl_t                ctl_i,
	input  logic signed [CW-1:0]     x_i,
	input  logic signed [CW-1:0]     y_i,
	input  logic signed [CW-1:0]     z_i,
	input  logic signed [TRIG_W-1:0] cos_i,
	input  logic signed [TRIG_W-1:0] sin_i,
	input  logic [1:0]               twist,
	input  logic signed [CW-1:0]     len,
	input  logic signed [CW-1:0]     ofs,
	output link_ctl_t                ctl_o,
	output logic signed [CW-1:0]     x_o,
	output logic signed [CW-1:0]     y_o,
	output logic signed [CW-1:0]     z_o
);

	localparam int PW = TRIG_W + CW + 1;
	localparam logic signed [PW:0] SMAX = {{(PW-CW+2){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [PW:0] SMIN = {{(PW-CW+2){1'b1}}, {(CW-1){1'b0}}};
	localparam logic signed [PW:0] RND  = (PW+1)'(1) <<< 29;
	localparam logic signed [CW+1:0] ZMAX = {3'b000, {(CW-1){1'b1}}};
	localparam logic signed [CW+1:0] ZMIN = {3'b111, {(CW-1){1'b0}}};

	link_ctl_t                ctl_s1, ctl_s2;
	logic signed [CW:0]       y1_s1, z1_s1, u_s1;
	logic signed [TRIG_W-1:0] c_s1, s_s1;
	logic signed [PW-1:0]     pcu_s2, psy_s2, psu_s2, pcy_s2;
	logic signed [CW+1:0]     zd_s2;
	logic signed [CW:0]       ye, ze, y1, z1;
	logic signed [PW:0]       rx, ry;
	logic                     sat_x, sat_y, sat_z, sat_any;
	logic signed [CW-1:0]     xs, ys, zs;

	always_comb begin
		ye = (CW+1)'(y_i);
		ze = (CW+1)'(z_i);
		unique case (quarter_t'(twist))
			QT_0:   begin y1 = ye;  z1 = ze;  end
			QT_90:  begin y1 = -ze; z1 = ye;  end
			QT_180: begin y1 = -ye; z1 = -ze; end
			QT_270: begin y1 = ze;  z1 = -ye; end
			default: begin y1 = ye; z1 = ze;  end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_o  <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_i;
			ctl_s2 <= ctl_s1;
			ctl_o  <= '{valid: ctl_s2.valid, sat: ctl_s2.sat | (ctl_s2.valid & sat_any)};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y1_s1  <= y1;
			z1_s1  <= z1;
			u_s1   <= (CW+1)'(x_i) + (CW+1)'(len);
			c_s1   <= cos_i;
			s_s1   <= sin_i;
			pcu_s2 <= PW'(c_s1) * PW'(u_s1);
			psy_s2 <= PW'(s_s1) * PW'(y1_s1);
			psu_s2 <= PW'(s_s1) * PW'(u_s1);
			pcy_s2 <= PW'(c_s1) * PW'(y1_s1);
			zd_s2  <= (CW+2)'(z1_s1) + (CW+2)'(ofs);
		end
	end

	always_comb begin
		rx = ((PW+1)'(pcu_s2) - (PW+1)'(psy_s2) + RND) >>> 30;
		ry = ((PW+1)'(psu_s2) + (PW+1)'(pcy_s2) + RND) >>> 30;
		sat_x = (rx > SMAX) || (rx < SMIN);
		sat_y = (ry > SMAX) || (ry < SMIN);
		sat_z = (zd_s2 > ZMAX) || (zd_s2 < ZMIN);
		xs = (rx > SMAX) ? CW'(SMAX) : ((rx < SMIN) ? CW'(SMIN) : CW'(rx));
		ys = (ry > SMAX) ? CW'(SMAX) : ((ry < SMIN) ? CW'(SMIN) : CW'(ry));
		zs = (zd_s2 > ZMAX) ? CW'(ZMAX) : ((zd_s2 < ZMIN) ? CW'(ZMIN) : CW'(zd_s2));
		sat_any = sat_x | sat_y | sat_z;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_o <= xs;
			y_o <= ys;
			z_o <= zs;
		end
	end

endmodule

### sv/dh_forward_kinematics_3joint.sv
// ----------------------------------------------------------------------------
// dh_forward_kinematics_3joint
// Three-link forward kinematics: pitch, roll, then yaw link on one point.
// ----------------------------------------------------------------------------
// An accepted pose word passes the point delay line, then the pitch, roll and yaw links.
// Throughput: one pose word per cycle while no result word is stalled; set by the
//   28-stage sine/cosine pipeline and three 3-stage link pipelines that all advance together.
// A stalled result word holds the whole pipeline; nothing is dropped.
// Reset clears valid bits and loads the register defaults.
module dh_forward_kinematics_3joint import dhfk_pkg::*; #(
	parameter int COORD_WIDTH = 24,
	parameter int ANGLE_WIDTH = 16
) (
	input  logic   clk,
	input  logic   arst_n,
	dhfk_pose_if.sink     pose,
	dhfk_result_if.source result,
	dhfk_cfg_if.sink      cfg
);

`include "dh_forward_kinematics_3joint_assert.svh"

	localparam int CW = COORD_WIDTH;
	localparam int AW = ANGLE_WIDTH;
	localparam int DEPTH = CORDIC_STEPS;

	logic signed [CW-1:0] yaw_len_q, pitch_len_q, roll_len_q;
	logic signed [CW-1:0] yaw_ofs_q, pitch_ofs_q, roll_ofs_q;
	logic [CODE_W-1:0]    twist_q, aofs_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_len_q   <= '0;
			pitch_len_q <= CW'(8192);
			roll_len_q  <= '0;
			yaw_ofs_q   <= CW'(8192);
			pitch_ofs_q <= '0;
			roll_ofs_q  <= '0;
			twist_q     <= TWIST_RESET;
			aofs_q      <= AOFS_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_YAW_LEN:   yaw_len_q   <= cfg.data;
				REG_PITCH_LEN: pitch_len_q <= cfg.data;
				REG_ROLL_LEN:  roll_len_q  <= cfg.data;
				REG_YAW_OFS:   yaw_ofs_q   <= cfg.data;
				REG_PITCH_OFS: pitch_ofs_q <= cfg.data;
				REG_ROLL_OFS:  roll_ofs_q  <= cfg.data;
				REG_TWIST:     twist_q     <= cfg.data[CODE_W-1:0];
				REG_ANGLE_OFS: aofs_q      <= cfg.data[CODE_W-1:0];
				default: ;
			endcase
		end
	end

	logic en;
	link_ctl_t ctl_p, ctl_r, ctl_y;

	assign en         = !ctl_y.valid || result.ready;
	assign pose.ready = en;

	logic [31:0] ph_yaw, ph_pitch, ph_roll;

	assign ph_yaw   = {pose.yaw_angle, {(32-AW){1'b0}}} + {aofs_q[1:0], 30'b0};
	assign ph_pitch = {pose.pitch_angle, {(32-AW){1'b0}}} + {aofs_q[3:2], 30'b0};
	assign ph_roll  = {pose.roll_angle, {(32-AW){1'b0}}} + {aofs_q[5:4], 30'b0};

	logic                 v_s  [0:DEPTH];
	logic signed [CW-1:0] px_s [0:DEPTH];
	logic signed [CW-1:0] py_s [0:DEPTH];
	logic signed [CW-1:0] pz_s [0:DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DEPTH; k++)
				v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[0] <= pose.valid;
			for (int k = 1; k <= DEPTH; k++)
				v_s[k] <= v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s[0] <= pose.point_x;
			py_s[0] <= pose.point_y;
			pz_s[0] <= pose.point_z;
			for (int k = 1; k <= DEPTH; k++) begin
				px_s[k] <= px_s[k-1];
				py_s[k] <= py_s[k-1];
				pz_s[k] <= pz_s[k-1];
			end
		end
	end

	logic signed [TRIG_W-1:0] c_p, s_p, c_r, s_r, c_y, s_y;

	dhfk_cordic #(.TAIL(0)) u_cordic_pitch (
		.clk(clk), .en(en), .phase(ph_pitch), .cos_o(c_p), .sin_o(s_p)
	);
	dhfk_cordic #(.TAIL(3)) u_cordic_roll (
		.clk(clk), .en(en), .phase(ph_roll), .cos_o(c_r), .sin_o(s_r)
	);
	dhfk_cordic #(.TAIL(6)) u_cordic_yaw (
		.clk(clk), .en(en), .phase(ph_yaw), .cos_o(c_y), .sin_o(s_y)
	);

	link_ctl_t ctl_in;
	logic signed [CW-1:0] xp, yp, zp, xr, yr, zr;

	assign ctl_in = '{valid: v_s[DEPTH], sat: 1'b0};

	dhfk_link #(.CW(CW)) u_link_pitch (
		.clk(clk), .arst_n(arst_n), .en(en), .ctl_i(ctl_in),
		.x_i(px_s[DEPTH]), .y_i(py_s[DEPTH]), .z_i(pz_s[DEPTH]),
		.cos_i(c_p), .sin_i(s_p), .twist(twist_q[3:2]),
		.len(pitch_len_q), .ofs(pitch_ofs_q),
		.ctl_o(ctl_p), .x_o(xp), .y_o(yp), .z_o(zp)
	);

	dhfk_link #(.CW(CW)) u_link_roll (
		.clk(clk), .arst_n(arst_n), .en(en), .ctl_i(ctl_p),
		.x_i(xp), .y_i(yp), .z_i(zp),
		.cos_i(c_r), .sin_i(s_r), .twist(twist_q[5:4]),
		.len(roll_len_q), .ofs(roll_ofs_q),
		.ctl_o(ctl_r), .x_o(xr), .y_o(yr), .z_o(zr)
	);

	dhfk_link #(.CW(CW)) u_link_yaw (
		.clk(clk), .arst_n(arst_n), .en(en), .ctl_i(ctl_r),
		.x_i(xr), .y_i(yr), .z_i(zr),
		.cos_i(c_y), .sin_i(s_y), .twist(twist_q[1:0]),
		.len(yaw_len_q), .ofs(yaw_ofs_q),
		.ctl_o(ctl_y), .x_o(result.out_x), .y_o(result.out_y), .z_o(result.out_z)
	);

	assign result.valid     = ctl_y.valid;
	assign result.saturated = ctl_y.sat;

	`ASSERT_IMPLY(a_stall_blocks_input, ctl_y.valid && !result.ready, !pose.ready, "input taken while output stalled")
	`ASSERT_IMPLY(a_empty_out_ready, !ctl_y.valid, pose.ready, "pipeline stalled with no output word")
	`ASSERT_NEXT(a_accept_enters, pose.valid && pose.ready, v_s[0], "accepted word not entered")
	`ASSERT_NEXT(a_stall_freezes, !en && !v_s[0], !v_s[0], "entry stage changed during stall")

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Streams poses through the three-link forward kinematics block. A local
// fixed-point model computes each expected point, and the monitor checks it.
// Registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb import dhfk_pkg::*; ();

	localparam int CW = 24;
	localparam int AW = 16;
	localparam int LIMIT = 400000;

	typedef struct {
		logic [AW-1:0] yaw, pitch, roll;
		logic signed [CW-1:0] px, py, pz;
	} pose_t;

	typedef struct {
		logic signed [CW-1:0] x, y, z;
		logic sat;
	} point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dhfk_pose_if #(.CW(CW), .AW(AW)) pose ();
	dhfk_result_if #(.CW(CW)) result ();
	dhfk_cfg_if #(.CW(CW)) cfg ();

	dh_forward_kinematics_3joint #(.COORD_WIDTH(CW), .ANGLE_WIDTH(AW)) u_top (
		.clk(clk), .arst_n(arst_n), .pose(pose.sink), .result(result.source),
		.cfg(cfg.sink)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	pose_t pose_q[$];
	point_t point_q[$];
	logic signed [CW-1:0] link_len[3], link_ofs[3];
	logic [5:0] twist, aofs;
	int errors = 0;
	int cycles = 0;
	bit calm = 0;
	bit cfg_req = 0;
	bit cfg_ack = 0;
	logic [3:0] cfg_idx;
	logic [CW-1:0] cfg_dat;

	function automatic longint shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic void sin_cos(input logic [31:0] phase, output longint c,
		output longint s);
		longint x, y, z, dx, dy, one;
		one = longint'(1) << 30;
		x = GAIN_INV;
		y = 0;
		z = phase[29:0];
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = shr(y, i);
			dy = shr(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(atan_lut(i));
			end else begin
				x += dx; y -= dy; z += longint'(atan_lut(i));
			end
		end
		if (x > one) x = one;
		if (x < -one) x = -one;
		if (y > one) y = one;
		if (y < -one) y = -one;
		case (quarter_t'(phase[31:30]))
			QT_0: begin c = x; s = y; end
			QT_90: begin c = -y; s = x; end
			QT_180: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endfunction

	function automatic longint clip(longint v, ref bit f);
		longint lim;
		lim = longint'(1) << (CW - 1);
		if (v > lim - 1) begin f = 1; return lim - 1; end
		if (v < -lim) begin f = 1; return -lim; end
		return v;
	endfunction

	function automatic void link(ref longint p[3], input logic [AW-1:0] ang,
		input logic [1:0] aq, input logic [1:0] tq, input longint a, input longint d,
		ref bit f);
		logic [31:0] ph;
		longint ct, st, ca, sa, y1, z1, u, rx, ry;
		ph = {ang, 16'd0} + {aq, 30'd0};
		sin_cos(ph, ct, st);
		case (quarter_t'(tq))
			QT_0: begin ca = 1; sa = 0; end
			QT_90: begin ca = 0; sa = 1; end
			QT_180: begin ca = -1; sa = 0; end
			default: begin ca = 0; sa = -1; end
		endcase
		y1 = ca * p[1] - sa * p[2];
		z1 = sa * p[1] + ca * p[2];
		u = p[0] + a;
		rx = ct * u - st * y1;
		ry = st * u + ct * y1;
		p[0] = clip(shr(rx + (longint'(1) << 29), 30), f);
		p[1] = clip(shr(ry + (longint'(1) << 29), 30), f);
		p[2] = clip(z1 + d, f);
	endfunction

	function automatic point_t transform_pose(pose_t w);
		longint p[3];
		bit f;
		point_t r;
		f = 0;
		p[0] = w.px; p[1] = w.py; p[2] = w.pz;
		link(p, w.pitch, aofs[3:2], twist[3:2], link_len[1], link_ofs[1], f);
		link(p, w.roll, aofs[5:4], twist[5:4], link_len[2], link_ofs[2], f);
		link(p, w.yaw, aofs[1:0], twist[1:0], link_len[0], link_ofs[0], f);
		r.x = CW'(p[0]); r.y = CW'(p[1]); r.z = CW'(p[2]); r.sat = f;
		return r;
	endfunction

	function automatic logic [CW-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return CW'($urandom_range(0, 8191) - 4096);
			3: return CW'($urandom);
			default: return CW'($urandom_range(0, 2000000) - 1000000);
		endcase
	endfunction

	function automatic pose_t rand_pose();
		pose_t w;
		w.yaw = AW'($urandom); w.pitch = AW'($urandom); w.roll = AW'($urandom);
		w.px = rand_coord(); w.py = rand_coord(); w.pz = rand_coord();
		return w;
	endfunction

	// driver: pose channel
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose.valid <= 1'b0;
			{pose.yaw_angle, pose.pitch_angle, pose.roll_angle} <= '0;
			{pose.point_x, pose.point_y, pose.point_z} <= '0;
		end else if (!pose.valid || pose.ready) begin
			if (pose.valid) point_q.push_back(transform_pose(pose_q.pop_front()));
			if (pose_q.size() > 0 && (calm || $urandom_range(0, 99) >= 38)) begin
				pose.valid <= 1'b1;
				pose.yaw_angle <= pose_q[0].yaw;
				pose.pitch_angle <= pose_q[0].pitch;
				pose.roll_angle <= pose_q[0].roll;
				pose.point_x <= pose_q[0].px;
				pose.point_y <= pose_q[0].py;
				pose.point_z <= pose_q[0].pz;
			end else begin
				pose.valid <= 1'b0;
			end
		end
	end

	// driver: register writes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.valid <= 1'b0;
			cfg.index <= '0;
			cfg.data <= '0;
		end else if (cfg.valid && cfg.ready) begin
			cfg.valid <= 1'b0;
			cfg_ack <= cfg_req;
		end else if (cfg_req != cfg_ack && !cfg.valid) begin
			cfg.valid <= 1'b1;
			cfg.index <= cfg_idx;
			cfg.data <= cfg_dat;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		point_t e;
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			cycles <= cycles + 1;
			if (result.valid && result.ready) begin
				if (point_q.size() == 0) begin
					$display("%0t: unexpected word x=%h", $time, result.out_x);
					errors <= errors + 1;
				end else begin
					e = point_q.pop_front();
					if (result.out_x !== e.x || result.out_y !== e.y ||
						result.out_z !== e.z || result.saturated !== e.sat) begin
						$display("%0t: expected %h %h %h %b actual %h %h %h %b", $time,
							e.x, e.y, e.z, e.sat, result.out_x, result.out_y,
							result.out_z, result.saturated);
						errors <= errors + 1;
					end
				end
			end
			result.ready <= calm || $urandom_range(0, 99) >= 38;
		end
	end

	always @(posedge clk) begin
		if (cycles > LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [CW-1:0] v);
		cfg_idx = idx;
		cfg_dat = v;
		@(posedge clk);
		cfg_req <= ~cfg_req;
		@(posedge clk);
		while (cfg_req != cfg_ack) @(posedge clk);
		case (idx)
			REG_YAW_LEN: link_len[0] = v;
			REG_PITCH_LEN: link_len[1] = v;
			REG_ROLL_LEN: link_len[2] = v;
			REG_YAW_OFS: link_ofs[0] = v;
			REG_PITCH_OFS: link_ofs[1] = v;
			REG_ROLL_OFS: link_ofs[2] = v;
			REG_TWIST: twist = v[5:0];
			default: aofs = v[5:0];
		endcase
	endtask

	task automatic drain();
		while (pose_q.size() > 0 || pose.valid || point_q.size() > 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic configure(input int mode);
		for (int r = 0; r < 6; r++) begin
			logic [CW-1:0] v;
			case (mode)
				0: v = 24'h7FFFFF;
				1: v = 24'h800000;
				2: v = '0;
				default: v = CW'($urandom_range(0, 40000) - 20000);
			endcase
			write_reg(cfg_reg_t'(r), v);
		end
		write_reg(REG_TWIST, CW'(mode == 0 ? 6'd63 : mode == 2 ? 6'd0 : 6'($urandom)));
		write_reg(REG_ANGLE_OFS, CW'(mode == 1 ? 6'd63 : mode == 2 ? 6'd0 : 6'($urandom)));
	endtask

	initial begin
		pose_t w;
		link_len[0] = 0; link_len[1] = 8192; link_len[2] = 0;
		link_ofs[0] = 8192; link_ofs[1] = 0; link_ofs[2] = 0;
		twist = TWIST_RESET;
		aofs = AOFS_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// directed: extremes of angles and points with reset registers
		for (int i = 0; i < 20; i++) begin
			w.yaw = (i % 4 == 0) ? 16'h0000 : (i % 4 == 1) ? 16'hFFFF :
				(i % 4 == 2) ? 16'h4000 : 16'h8000;
			w.pitch = (i & 1) ? 16'hFFFF : 16'h0000;
			w.roll = (i & 2) ? 16'hC000 : 16'h2000;
			w.px = (i < 5) ? 24'h7FFFFF : (i < 10) ? 24'h800000 : (i < 15) ? 24'h0 : 24'h001000;
			w.py = (i & 4) ? 24'h800000 : 24'h7FFFFF;
			w.pz = (i & 8) ? 24'h7FFFFF : 24'hFFF000;
			pose_q.push_back(w);
		end
		drain();
		for (int ph = 0; ph < 7; ph++) begin
			configure(ph < 3 ? ph : 3);
			calm = (ph == 4);
			for (int i = 0; i < 150; i++) pose_q.push_back(rand_pose());
			drain();
		end
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
